FILE: design/fqat_pkg.sv
// fqat_pkg: shared widths, state codes and lane interface structs
// for the tail-drop queue timing block. No dependencies.
package fqat_pkg;

  localparam int TIME_W   = 40;  // 24.16 time values
  localparam int SVC_W    = 32;  // 16.16 service time
  localparam int CNT_W    = 32;  // saturating event counters
  localparam int SUM_W    = 64;  // 48.16 running sums
  localparam int SIDX_W   = 2;   // server index field
  localparam int LIM_W    = 5;   // queue limit register
  localparam int NUM_LIMITS = 4;
  localparam int DEF_SERVERS = 4;
  localparam int DEF_DEPTH   = 16;
  localparam logic [LIM_W-1:0] LIM_RESET = 5'd16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOCK,
    S_PURGE,
    S_CALC,
    S_COMMIT
  } state_t;

  // per-lane command from the sequencer
  typedef struct packed {
    logic pop;      // drop head entry, chain shifts toward head
    logic push;     // append entry at tail
    logic set_clk;  // move server clock up to arrival
  } lane_cmd_t;

  // per-lane status seen by the sequencer
  typedef struct packed {
    logic              empty;
    logic [TIME_W-1:0] head;
    logic [TIME_W-1:0] tail;
    logic [TIME_W-1:0] clock;
  } lane_sts_t;

endpackage

FILE: design/fqat_cell.sv
// fqat_cell: one queue slot holding a finish time.
// Depends on fqat_pkg.
module fqat_cell
  import fqat_pkg::*;
(
  input  logic              clk,
  input  logic              shift,
  input  logic              load,
  input  logic [TIME_W-1:0] nb_val,
  input  logic [TIME_W-1:0] ld_val,
  output logic [TIME_W-1:0] val
);

  logic [TIME_W-1:0] val_r;

  // load wins; shift takes the value of the cell behind
  always_ff @(posedge clk) begin
    if (load) begin
      val_r <= ld_val;
    end else if (shift) begin
      val_r <= nb_val;
    end
  end

  assign val = val_r;

endmodule

FILE: design/fqat_lane.sv
// fqat_lane: one server's queue as a chain of fqat_cell slots, head at
// slot zero, plus its fill count, server clock and last finish time.
// Depends on fqat_pkg and fqat_cell.
module fqat_lane
  import fqat_pkg::*;
#(
  parameter int DEPTH = DEF_DEPTH,
  localparam int CW = $clog2(DEPTH + 1)
)(
  input  logic              clk,
  input  logic              rst_n,
  input  lane_cmd_t         cmd,
  input  logic [TIME_W-1:0] push_val,
  input  logic [TIME_W-1:0] clk_val,
  output lane_sts_t         sts,
  output logic [CW-1:0]     count
);

  logic [CW-1:0]     count_r, count_nxt;
  logic [TIME_W-1:0] clock_r;
  logic [TIME_W-1:0] tail_r;
  logic [TIME_W-1:0] slot_val [DEPTH];

  genvar k;
  generate
    for (k = 0; k < DEPTH; k++) begin : g_slot
      logic [TIME_W-1:0] nb;
      if (k == DEPTH - 1) begin : g_last
        assign nb = slot_val[k];
      end else begin : g_mid
        assign nb = slot_val[k+1];
      end
      fqat_cell u_cell (
        .clk    (clk),
        .shift  (cmd.pop),
        .load   (cmd.push && (count_r == CW'(k))),
        .nb_val (nb),
        .ld_val (push_val),
        .val    (slot_val[k])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      clock_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (cmd.set_clk) begin
        clock_r <= clk_val;
      end
    end
  end

  // last pushed finish; only read while the queue is non-empty
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      tail_r <= push_val;
    end
  end

  assign sts.empty = (count_r == '0);
  assign sts.head  = slot_val[0];
  assign sts.tail  = tail_r;
  assign sts.clock = clock_r;
  assign count     = count_r;

endmodule

FILE: design/finite_queue_admission_timing.sv
// finite_queue_admission_timing: tail-drop admission timing over a set of
// single-server FIFO queues; sequencer, limits, totals and result register.
// Depends on fqat_pkg and fqat_lane.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-----------------------------------
//  in_     | input     | in_valid/in_ready  | server index, arrival, service
//  out_    | output    | out_valid/out_ready| admit flag, wait, finish, totals
//  cfg_    | input     | cfg_we only        | queue limit per server
//
// Steps: after acceptance a word passes CLOCK, PURGE, CALC and COMMIT; the
//   next word is taken only back in IDLE. PURGE pops finished entries from
//   that server's queue, one pop per cycle, set by the shift of the slot chain.
// Reset: rst_n synchronous, active low; counts, clocks and totals clear,
//   limits return to 16. Slot contents are not cleared.
// Stalls: a result waits in the output register while the next word is
//   accepted and worked on; that word only stalls at its commit step.
module finite_queue_admission_timing
  import fqat_pkg::*;
#(
  parameter int SERVERS     = DEF_SERVERS,
  parameter int QUEUE_DEPTH = DEF_DEPTH
)(
  input  logic               clk,
  input  logic               rst_n,
  // input word
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SIDX_W-1:0]  in_server_index,
  input  logic [TIME_W-1:0]  in_arrival_time,
  input  logic [SVC_W-1:0]   in_service_time,
  // result word
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_accepted,
  output logic [TIME_W-1:0]  out_wait_time,
  output logic [TIME_W-1:0]  out_finish_time,
  output logic [CNT_W-1:0]   out_accepted_count,
  output logic [CNT_W-1:0]   out_rejected_count,
  output logic [TIME_W-1:0]  out_latest_finish,
  output logic [SUM_W-1:0]   out_wait_sum,
  output logic [SUM_W-1:0]   out_service_sum,
  // configuration
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [LIM_W-1:0]   cfg_data
);

  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int CMPW = (CW > LIM_W) ? CW : LIM_W;
  localparam int SELW = (SERVERS > 1) ? $clog2(SERVERS) : 1;

  // ---------------------------------------------------------------------
  // configuration: queue limits
  // ---------------------------------------------------------------------
  logic [LIM_W-1:0] limit_r [NUM_LIMITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LIMITS; i++) begin
        limit_r[i] <= LIM_RESET;
      end
    end else if (cfg_we) begin
      limit_r[cfg_index] <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------
  // captured word and working registers
  // ---------------------------------------------------------------------
  state_t            state_r, state_nxt;
  logic [SIDX_W-1:0] srv_r;
  logic [TIME_W-1:0] arr_r;
  logic [SVC_W-1:0]  svc_r;
  logic              acc_r;
  logic [TIME_W-1:0] wait_r;
  logic [TIME_W-1:0] fin_r;

  logic [SELW-1:0]   sel;
  logic              in_range;
  logic              do_pop, do_push, do_setclk, commit;

  assign sel      = SELW'(srv_r);
  assign in_range = (int'(srv_r) < SERVERS);

  // ---------------------------------------------------------------------
  // server lanes
  // ---------------------------------------------------------------------
  lane_cmd_t lane_cmd [SERVERS];
  lane_sts_t lane_sts [SERVERS];
  logic [CW-1:0] lane_cnt [SERVERS];
  lane_sts_t     sts_sel;
  logic [CW-1:0] cnt_sel;

  genvar g;
  generate
    for (g = 0; g < SERVERS; g++) begin : g_lane
      assign lane_cmd[g].pop     = do_pop    && in_range && (sel == SELW'(g));
      assign lane_cmd[g].push    = do_push   && in_range && (sel == SELW'(g));
      assign lane_cmd[g].set_clk = do_setclk && in_range && (sel == SELW'(g));
      fqat_lane #(.DEPTH(QUEUE_DEPTH)) u_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (lane_cmd[g]),
        .push_val (fin_r),
        .clk_val  (arr_r),
        .sts      (lane_sts[g]),
        .count    (lane_cnt[g])
      );
    end
  endgenerate

  always_comb begin
    sts_sel = '0;
    cnt_sel = '0;
    for (int i = 0; i < SERVERS; i++) begin
      if (sel == SELW'(i)) begin
        sts_sel = lane_sts[i];
        cnt_sel = lane_cnt[i];
      end
    end
  end

  // effective limit saturates at the queue depth
  logic [CMPW-1:0] lim_ext, cnt_ext, eff_lim;
  assign lim_ext = CMPW'(limit_r[srv_r]);
  assign cnt_ext = CMPW'(cnt_sel);
  assign eff_lim = (lim_ext > CMPW'(QUEUE_DEPTH)) ? CMPW'(QUEUE_DEPTH) : lim_ext;

  // head entry finished before the server clock -> pop it
  logic purge_hit;
  assign purge_hit = in_range && !sts_sel.empty && (sts_sel.head < sts_sel.clock);

  // ---------------------------------------------------------------------
  // admission math (CALC step)
  // ---------------------------------------------------------------------
  logic              acc_c;
  logic [TIME_W-1:0] base_c;
  logic [TIME_W:0]   fin_sum;
  logic [TIME_W-1:0] fin_c, wait_c;

  assign acc_c   = in_range && (cnt_ext < eff_lim);
  assign base_c  = sts_sel.empty ? sts_sel.clock : sts_sel.tail;
  assign fin_sum = {1'b0, base_c} + (TIME_W+1)'(svc_r);

  always_comb begin
    fin_c  = '0;
    wait_c = '0;
    if (acc_c) begin
      fin_c = fin_sum[TIME_W] ? {TIME_W{1'b1}} : fin_sum[TIME_W-1:0];
      if (!sts_sel.empty && (sts_sel.tail >= arr_r)) begin
        wait_c = sts_sel.tail - arr_r;
      end
    end
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  logic out_valid_r;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    do_pop    = 1'b0;
    do_push   = 1'b0;
    do_setclk = 1'b0;
    commit    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = S_CLOCK;
        end
      end
      S_CLOCK: begin
        // clock never moves back
        do_setclk = (arr_r > sts_sel.clock);
        state_nxt = S_PURGE;
      end
      S_PURGE: begin
        if (purge_hit) begin
          do_pop = 1'b1;
        end else begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (!out_valid_r || out_ready) begin
          commit    = 1'b1;
          do_push   = acc_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      srv_r <= in_server_index;
      arr_r <= in_arrival_time;
      svc_r <= in_service_time;
    end
    if (state_r == S_CALC) begin
      acc_r  <= acc_c;
      wait_r <= wait_c;
      fin_r  <= fin_c;
    end
  end

  // ---------------------------------------------------------------------
  // running totals; they only change at commit, which waits for the
  // output register to drain, so they double as the result's totals
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0]  acc_cnt_r, rej_cnt_r;
  logic [TIME_W-1:0] latest_r;
  logic [SUM_W-1:0]  wait_tot_r, svc_tot_r;
  logic [SUM_W:0]    wait_add, svc_add;

  assign wait_add = {1'b0, wait_tot_r} + (SUM_W+1)'(wait_r);
  assign svc_add  = {1'b0, svc_tot_r} + (SUM_W+1)'(svc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_cnt_r  <= '0;
      rej_cnt_r  <= '0;
      latest_r   <= '0;
      wait_tot_r <= '0;
      svc_tot_r  <= '0;
    end else if (commit) begin
      if (acc_r) begin
        if (acc_cnt_r != {CNT_W{1'b1}}) begin
          acc_cnt_r <= acc_cnt_r + 1'b1;
        end
        wait_tot_r <= wait_add[SUM_W] ? {SUM_W{1'b1}} : wait_add[SUM_W-1:0];
        svc_tot_r  <= svc_add[SUM_W]  ? {SUM_W{1'b1}} : svc_add[SUM_W-1:0];
        if (fin_r > latest_r) begin
          latest_r <= fin_r;
        end
      end else if (rej_cnt_r != {CNT_W{1'b1}}) begin
        rej_cnt_r <= rej_cnt_r + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  logic              out_acc_r;
  logic [TIME_W-1:0] out_wait_r, out_fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_acc_r  <= acc_r;
      out_wait_r <= wait_r;
      out_fin_r  <= fin_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = out_acc_r;
  assign out_wait_time      = out_wait_r;
  assign out_finish_time    = out_fin_r;
  assign out_accepted_count = acc_cnt_r;
  assign out_rejected_count = rej_cnt_r;
  assign out_latest_finish  = latest_r;
  assign out_wait_sum       = wait_tot_r;
  assign out_service_sum    = svc_tot_r;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> (!out_valid_r || out_ready))
    else $error("commit while result register still held");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_accepted) |-> (out_wait_time == '0 && out_finish_time == '0))
    else $error("dropped word carries wait or finish");

  a_latest_cover: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_accepted) |-> (out_latest_finish >= out_finish_time))
    else $error("latest finish below reported finish");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_range |-> (cnt_ext <= CMPW'(QUEUE_DEPTH)))
    else $error("queue count above depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |-> (cnt_ext < CMPW'(QUEUE_DEPTH)))
    else $error("push into a full queue");

endmodule

FILE: test/tb_finite_queue_admission_timing.sv
// tb_finite_queue_admission_timing: self-checking bench for the tail-drop queue timing block,
// with a per-server queue predictor in a scoreboard class and handshake driver tasks.
// Depends on fqat_pkg and finite_queue_admission_timing.
module tb_finite_queue_admission_timing;
  import fqat_pkg::*;

  localparam logic [TIME_W-1:0] TIME_TOP = '1;
  localparam logic [SVC_W-1:0]  SVC_TOP  = '1;
  localparam int PHASE_WORDS = 170;
  localparam int HOLD_AFTER  = 300;  // results seen before the long output stall
  localparam int HOLD_CYCLES = 400;

  // one expected result word
  typedef struct {
    logic              accepted;
    logic [TIME_W-1:0] wait_time;
    logic [TIME_W-1:0] finish_time;
    logic [CNT_W-1:0]  accepted_count;
    logic [CNT_W-1:0]  rejected_count;
    logic [TIME_W-1:0] latest_finish;
    logic [SUM_W-1:0]  wait_sum;
    logic [SUM_W-1:0]  service_sum;
  } verdict_t;

  // Scoreboard: mirrors every server queue, works out the verdict of each
  // accepted word and matches result words against those verdicts in order.
  class admission_scoreboard;
    logic [TIME_W-1:0] finish_ring [DEF_SERVERS][DEF_DEPTH];
    int unsigned       ring_head   [DEF_SERVERS];
    int unsigned       ring_count  [DEF_SERVERS];
    logic [TIME_W-1:0] server_now  [DEF_SERVERS];
    logic [LIM_W-1:0]  limit_reg   [NUM_LIMITS];
    logic [CNT_W-1:0]  admit_total;
    logic [CNT_W-1:0]  drop_total;
    logic [TIME_W-1:0] latest_end;
    logic [SUM_W-1:0]  wait_acc;
    logic [SUM_W-1:0]  svc_acc;
    verdict_t          verdict_q[$];
    int                errors;

    function new();
      for (int s = 0; s < DEF_SERVERS; s++) begin
        ring_head[s]  = 0;
        ring_count[s] = 0;
        server_now[s] = '0;
      end
      for (int i = 0; i < NUM_LIMITS; i++) limit_reg[i] = LIM_RESET;
      admit_total = '0;
      drop_total  = '0;
      latest_end  = '0;
      wait_acc    = '0;
      svc_acc     = '0;
      errors      = 0;
    endfunction

    function void set_limit(int idx, logic [LIM_W-1:0] val);
      if (idx < NUM_LIMITS) limit_reg[idx] = val;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    // predictor: purge, admit or drop, update totals
    function void note_word(logic [SIDX_W-1:0] sidx, logic [TIME_W-1:0] arr,
                            logic [SVC_W-1:0] svc);
      verdict_t          v;
      int unsigned       s;
      int unsigned       lim;
      logic [TIME_W-1:0] base;
      logic [TIME_W:0]   fin_wide;
      logic [SUM_W:0]    sum_wide;
      s = sidx;
      v.accepted    = 1'b0;
      v.wait_time   = '0;
      v.finish_time = '0;
      if (s < DEF_SERVERS) begin
        lim = (s < NUM_LIMITS) ? limit_reg[s] : DEF_DEPTH;
        if (lim > DEF_DEPTH) lim = DEF_DEPTH;
        // clock never moves back
        if (arr > server_now[s]) server_now[s] = arr;
        while (ring_count[s] > 0 && finish_ring[s][ring_head[s]] < server_now[s]) begin
          ring_head[s] = (ring_head[s] + 1) % DEF_DEPTH;
          ring_count[s]--;
        end
        if (ring_count[s] < lim) begin
          if (ring_count[s] > 0) begin
            base = finish_ring[s][(ring_head[s] + ring_count[s] - 1) % DEF_DEPTH];
            v.wait_time = (base >= arr) ? base - arr : '0;
          end else begin
            base = server_now[s];
          end
          fin_wide      = {1'b0, base} + svc;
          v.finish_time = fin_wide[TIME_W] ? TIME_TOP : fin_wide[TIME_W-1:0];
          finish_ring[s][(ring_head[s] + ring_count[s]) % DEF_DEPTH] = v.finish_time;
          ring_count[s]++;
          v.accepted = 1'b1;
        end
      end
      if (v.accepted) begin
        if (admit_total != '1) admit_total++;
        sum_wide = {1'b0, wait_acc} + v.wait_time;
        wait_acc = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        sum_wide = {1'b0, svc_acc} + svc;
        svc_acc  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        if (v.finish_time > latest_end) latest_end = v.finish_time;
      end else begin
        if (drop_total != '1) drop_total++;
      end
      v.accepted_count = admit_total;
      v.rejected_count = drop_total;
      v.latest_finish  = latest_end;
      v.wait_sum       = wait_acc;
      v.service_sum    = svc_acc;
      verdict_q.insert(verdict_q.size(), v);
    endfunction

    function void report_field(string name, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(verdict_t got);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        $display("%0t: result word with nothing expected", $time);
        errors++;
        return;
      end
      want = verdict_q.pop_front();
      report_field("accepted",       want.accepted,       got.accepted);
      report_field("wait_time",      want.wait_time,      got.wait_time);
      report_field("finish_time",    want.finish_time,    got.finish_time);
      report_field("accepted_count", want.accepted_count, got.accepted_count);
      report_field("rejected_count", want.rejected_count, got.rejected_count);
      report_field("latest_finish",  want.latest_finish,  got.latest_finish);
      report_field("wait_sum",       want.wait_sum,       got.wait_sum);
      report_field("service_sum",    want.service_sum,    got.service_sum);
    endfunction
  endclass

  // ---------------------------------------------------------------- signals
  logic               clk   = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [SIDX_W-1:0]  in_server_index = '0;
  logic [TIME_W-1:0]  in_arrival_time = '0;
  logic [SVC_W-1:0]   in_service_time = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_accepted;
  logic [TIME_W-1:0]  out_wait_time;
  logic [TIME_W-1:0]  out_finish_time;
  logic [CNT_W-1:0]   out_accepted_count;
  logic [CNT_W-1:0]   out_rejected_count;
  logic [TIME_W-1:0]  out_latest_finish;
  logic [SUM_W-1:0]   out_wait_sum;
  logic [SUM_W-1:0]   out_service_sum;
  logic               cfg_we    = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [LIM_W-1:0]   cfg_data  = '0;

  admission_scoreboard board = new();

  // per-server arrival cursor for the random part
  logic [TIME_W-1:0] last_arr [DEF_SERVERS];

  finite_queue_admission_timing i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_server_index    (in_server_index),
    .in_arrival_time    (in_arrival_time),
    .in_service_time    (in_service_time),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_accepted       (out_accepted),
    .out_wait_time      (out_wait_time),
    .out_finish_time    (out_finish_time),
    .out_accepted_count (out_accepted_count),
    .out_rejected_count (out_rejected_count),
    .out_latest_finish  (out_latest_finish),
    .out_wait_sum       (out_wait_sum),
    .out_service_sum    (out_service_sum),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Safety net: far above the slowest legal run (every word popping a full
  // queue, worst sender gaps, worst output stalls and the long hold).
  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- driver
  // Offer one word and hold it until taken. Valid stays high on return so
  // back-to-back words need no extra assignment in the same step.
  // Signals are read right after the edge, so they hold their pre-edge values.
  task automatic send_word(logic [SIDX_W-1:0] sidx, logic [TIME_W-1:0] arr,
                           logic [SVC_W-1:0] svc);
    in_valid        <= 1'b1;
    in_server_index <= sidx;
    in_arrival_time <= arr;
    in_service_time <= svc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_word(sidx, arr, svc);
  endtask

  task automatic idle_gap(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drain everything, let the block settle, then load all four limits.
  task automatic settle_and_config(logic [LIM_W-1:0] l0, logic [LIM_W-1:0] l1,
                                   logic [LIM_W-1:0] l2, logic [LIM_W-1:0] l3);
    logic [LIM_W-1:0] lims [NUM_LIMITS];
    lims[0] = l0;
    lims[1] = l1;
    lims[2] = l2;
    lims[3] = l3;
    idle_gap(1);
    while (board.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    for (int i = 0; i < NUM_LIMITS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= lims[i];
      @(posedge clk);
      cfg_we    <= 1'b0;
      board.set_limit(i, lims[i]);
      @(posedge clk);
    end
  endtask

  // Random traffic: mostly nondecreasing arrivals per server so queues build
  // and drain, a few arrivals behind the server clock, a mix of tiny, normal
  // and full-range service times, sent in bursts with random gaps.
  task automatic run_phase(int n_words);
    int                sent;
    int                burst;
    int                s;
    int                r;
    int unsigned       back;
    logic [TIME_W-1:0] step;
    logic [TIME_W-1:0] arr;
    logic [SVC_W-1:0]  svc;
    sent = 0;
    while (sent < n_words) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        s = $urandom_range(0, DEF_SERVERS - 1);
        r = $urandom_range(0, 99);
        if (r < 10)      svc = $urandom;
        else if (r < 20) svc = $urandom_range(0, 255);
        else             svc = $urandom_range(0, 1 << 20);
        r = $urandom_range(0, 99);
        if (r < 45)      step = TIME_W'($urandom_range(0, 1 << 16));
        else if (r < 80) step = TIME_W'($urandom_range(0, 1 << 21));
        else if (r < 95) step = TIME_W'($urandom_range(1 << 22, 1 << 26));
        else             step = {8'd0, $urandom};
        if ($urandom_range(0, 19) == 0) begin
          // behind the server clock; cursor unchanged
          back = $urandom_range(0, 1 << 18);
          arr  = (last_arr[s] > back) ? last_arr[s] - back : '0;
        end else begin
          arr         = last_arr[s] + step;
          last_arr[s] = arr;
        end
        send_word(SIDX_W'(s), arr, svc);
        sent++;
      end
      // a quarter of bursts run straight into the next one
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
  endtask

  // ---------------------------------------------------------------- sink
  // out_ready follows a mode picked per window: always ready, coin flip,
  // one-in-N periodic, or mostly ready. After HOLD_AFTER results it holds
  // off for HOLD_CYCLES so the block fills and backs up its input.
  initial begin : result_sink
    verdict_t got;
    int       mode;
    int       period;
    int       window;
    int       cyc;
    int       seen;
    int       hold_left;
    bit       held;
    bit       ready_next;
    mode      = 0;
    period    = 1;
    window    = 0;
    cyc       = 0;
    seen      = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.accepted       = out_accepted;
        got.wait_time      = out_wait_time;
        got.finish_time    = out_finish_time;
        got.accepted_count = out_accepted_count;
        got.rejected_count = out_rejected_count;
        got.latest_finish  = out_latest_finish;
        got.wait_sum       = out_wait_sum;
        got.service_sum    = out_service_sum;
        board.check_word(got);
        seen++;
      end
      if (!held && seen >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (window == 0) begin
        mode   = $urandom_range(0, 3);
        period = $urandom_range(2, 7);
        window = $urandom_range(16, 96);
      end
      window--;
      cyc++;
      if (hold_left > 0) begin
        ready_next = 1'b0;
        hold_left--;
      end else begin
        case (mode)
          0: ready_next = 1'b1;
          1: ready_next = 1'($urandom_range(0, 1));
          2: ready_next = (cyc % period) == 0;
          default: ready_next = $urandom_range(0, 7) != 0;
        endcase
      end
      out_ready <= ready_next;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: limit above depth on server 0, limit zero on server 1,
    // a two-deep queue on server 2.
    settle_and_config(5'd31, 5'd0, 5'd2, 5'd16);
    send_word(2'd0, '0, '0);                     // all-zero word, empty queue
    send_word(2'd0, '0, 32'h0001_0000);          // queued behind a zero finish
    send_word(2'd0, 40'h8000, SVC_TOP);          // full service, nonzero wait
    send_word(2'd1, 40'h100, 32'd5);             // limit zero: dropped
    send_word(2'd2, 40'h1000, 32'h100);
    send_word(2'd2, 40'h1000, 32'h100);
    send_word(2'd2, 40'h1000, 32'h100);          // queue at limit: dropped
    send_word(2'd2, 40'h1150, 32'h80);           // head finished: one pop
    send_word(2'd2, 40'h1000, 32'h40);           // arrival behind the clock
    send_word(2'd2, 40'h10_0000, 32'h20);        // everything finished: full purge
    send_word(2'd3, 40'h55_5555_5555, 32'hAAAA_AAAA);
    send_word(2'd3, 40'hAA_AAAA_AAAA, 32'h5555_5555);
    send_word(2'd0, 40'h8000, '0);               // zero service on a busy queue

    // random part, cursors spread over the time range
    last_arr[0] = 40'h20_0000;
    last_arr[1] = {8'd0, $urandom};
    last_arr[2] = {2'b00, 6'($urandom), $urandom};
    last_arr[3] = 40'hC0_0000_0000 + {4'd0, 4'($urandom), $urandom};

    settle_and_config(5'd16, 5'd16, 5'd16, 5'd16);
    run_phase(PHASE_WORDS);
    settle_and_config(5'd31, 5'd1, 5'd4, 5'd8);
    run_phase(PHASE_WORDS);
    settle_and_config(5'd0, 5'd31, 5'd16, 5'd3);
    run_phase(PHASE_WORDS);
    repeat (2) begin
      settle_and_config(LIM_W'($urandom_range(0, 31)), LIM_W'($urandom_range(0, 31)),
                        LIM_W'($urandom_range(0, 31)), LIM_W'($urandom_range(0, 31)));
      run_phase(PHASE_WORDS);
    end

    // Closing: finish saturation on server 3; it stays pinned at the top
    // afterwards, so this comes last.
    settle_and_config(5'd31, 5'd2, 5'd0, 5'd16);
    send_word(2'd3, TIME_TOP - 40'h10, SVC_TOP);
    send_word(2'd3, TIME_TOP, '0);
    send_word(2'd3, '0, 32'd1);

    idle_gap(1);
    while (board.pending() > 0) @(posedge clk);
    repeat (24) @(posedge clk);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
